/* rtl/wtsp_pkg.sv */
// Shared types and constants of the world-to-screen projection block.
package wtsp_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned EXT_W     = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_REGS  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_X_XY    = 3'd0,
    REG_COL_X_ZW    = 3'd1,
    REG_COL_Y_XY    = 3'd2,
    REG_COL_Y_ZW    = 3'd3,
    REG_COL_W_XY    = 3'd4,
    REG_COL_W_ZW    = 3'd5,
    REG_VP_SIZE     = 3'd6,
    REG_VP_ORIGIN   = 3'd7
  } wtsp_reg_e;

  typedef logic [CFG_W-1:0] wtsp_cfg_t;

  localparam wtsp_cfg_t REG_RESET [NUM_REGS] = '{
    64'd281474976710656, 64'd0, 64'd65536, 64'd0,
    64'd0, 64'd65536, 64'd125830200, 64'd0
  };

  localparam wtsp_cfg_t MASK_32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic                      inside_view;
    logic                      zero_depth;
  } wtsp_res_t;

endpackage

/* rtl/wtsp_ifs.sv */
// Valid/ready channel interfaces for world points and screen results.
interface wtsp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [wtsp_pkg::COORD_W-1:0] world_x;
  logic signed [wtsp_pkg::COORD_W-1:0] world_y;
  logic signed [wtsp_pkg::COORD_W-1:0] world_z;
  logic                                outside_mode;

  modport source (output valid, world_x, world_y, world_z, outside_mode, input ready);
  modport sink (input valid, world_x, world_y, world_z, outside_mode, output ready);
endinterface

interface wtsp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wtsp_pkg::COORD_W-1:0] screen_x;
  logic signed [wtsp_pkg::COORD_W-1:0] screen_y;
  logic                                inside_view;
  logic                                zero_depth;

  modport source (output valid, screen_x, screen_y, inside_view, zero_depth, input ready);
  modport sink (input valid, screen_x, screen_y, inside_view, zero_depth, output ready);
endinterface

/* rtl/wtsp_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module wtsp_div #(
  parameter int unsigned NUM_W  = 92,
  parameter int unsigned DEN_W  = 68,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]  v_q;
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  acc_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  acc_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign acc_in  = acc_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, acc_in[NUM_W-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        acc_q[k]  <= {acc_in[NUM_W-2:0], take};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quo_o   = acc_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

/* rtl/world_to_screen_projection.sv */
// Top level: projects world points through a view-projection matrix onto the viewport.
// Accepts one point per clock and returns one screen word per point, in order. The path from
// input acceptance to output valid runs through seven register stages for the matrix
// products, sums, divisor and numerator scaling, then one restoring-divider stage per
// quotient bit (84 + COORD_FRAC_BITS), then a two-entry output buffer. Input ready drops
// only while that buffer is full.
module world_to_screen_projection #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wtsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wtsp_pkg::CFG_W-1:0]      cfg_data_i,
  wtsp_in_if.sink                         in_i,
  wtsp_out_if.source                      out_o
);
  import wtsp_pkg::*;

  localparam int unsigned F      = COORD_FRAC_BITS;
  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned CW     = PROD_W + 2;
  localparam int unsigned DW     = CW + 1;
  localparam int unsigned NW     = DW + 1;
  localparam int unsigned HALF   = NW / 2;
  localparam int unsigned SC_W   = EXT_W + F;
  localparam int unsigned PP_W   = (NW - HALF) + SC_W;
  localparam int unsigned MW     = NW + SC_W;
  localparam logic [63:0] LIM    = 64'h4000_0000_0000_0000;

  // configuration
  wtsp_cfg_t cfg_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= REG_RESET[i];
    end else if (cfg_we_i) begin
      case (wtsp_reg_e'(cfg_idx_i))
        REG_VP_SIZE, REG_VP_ORIGIN: cfg_q[cfg_idx_i] <= cfg_data_i & MASK_32;
        default:                    cfg_q[cfg_idx_i] <= cfg_data_i;
      endcase
    end
  end

  logic signed [COEF_W-1:0] coef [3][4];
  for (genvar c = 0; c < 3; c++) begin : g_coef
    assign coef[c][0] = cfg_q[2*c][63:32];
    assign coef[c][1] = cfg_q[2*c][31:0];
    assign coef[c][2] = cfg_q[2*c+1][63:32];
    assign coef[c][3] = cfg_q[2*c+1][31:0];
  end

  logic [EXT_W-1:0] vp_w, vp_h, org_x, org_y;
  assign vp_w  = cfg_q[REG_VP_SIZE][31:16];
  assign vp_h  = cfg_q[REG_VP_SIZE][15:0];
  assign org_x = cfg_q[REG_VP_ORIGIN][31:16];
  assign org_y = cfg_q[REG_VP_ORIGIN][15:0];

  // flow control
  logic       en;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign en       = (cnt_q != 2'd2);
  assign in_i.ready = en;

  // stage 0: capture
  logic                     v0_q;
  logic signed [COORD_W-1:0] crd0_q [3];
  logic                     out0_q;

  // stage 1: products
  logic                     v1_q, out1_q;
  logic signed [PROD_W-1:0] p1_q [3][3];

  // stage 2: column sums
  logic                 v2_q, out2_q;
  logic signed [CW-1:0] col2_q [3];

  // stage 3: divisor and numerators
  logic                 v3_q, zero3_q, inside3_q;
  logic signed [NW-1:0] numx3_q, numy3_q, den3_q;

  // stage 4: magnitudes
  logic          v4_q, zero4_q, inside4_q, negx4_q, negy4_q;
  logic [NW-1:0] anx4_q, any4_q, aden4_q;

  // stage 5: partial products
  logic            v5_q, zero5_q, inside5_q, negx5_q, negy5_q;
  logic [NW-1:0]   aden5_q;
  logic [PP_W-1:0] ppxl5_q, ppxh5_q, ppyl5_q, ppyh5_q;

  // stage 6: dividends
  logic          v6_q, zero6_q, inside6_q, negx6_q, negy6_q;
  logic [NW-1:0] aden6_q;
  logic [MW-1:0] mx6_q, my6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  logic signed [DW-1:0] d3;
  logic [SC_W-1:0]      scl_x, scl_y;

  always_comb begin
    d3 = DW'(col2_q[2]);
    if (out2_q && col2_q[2][CW-1]) d3 = -d3;
  end

  assign scl_x = SC_W'(vp_w) << F;
  assign scl_y = SC_W'(vp_h) << F;

  always_ff @(posedge clk_i) begin
    if (en) begin
      crd0_q[0] <= in_i.world_x;
      crd0_q[1] <= in_i.world_y;
      crd0_q[2] <= in_i.world_z;
      out0_q    <= in_i.outside_mode;

      out1_q <= out0_q;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          p1_q[c][k] <= PROD_W'(coef[c][k]) * PROD_W'(crd0_q[k]);
        end
      end

      out2_q <= out1_q;
      for (int c = 0; c < 3; c++) begin
        col2_q[c] <= CW'(p1_q[c][0]) + CW'(p1_q[c][1]) + CW'(p1_q[c][2])
                   + (CW'(coef[c][3]) <<< F);
      end

      zero3_q   <= (col2_q[2] == '0);
      inside3_q <= !col2_q[2][CW-1] && (col2_q[2] != '0);
      numx3_q   <= NW'(d3) + NW'(col2_q[0]);
      numy3_q   <= NW'(d3) - NW'(col2_q[1]);
      den3_q    <= NW'(d3) <<< 1;

      zero4_q   <= zero3_q;
      inside4_q <= inside3_q;
      negx4_q   <= numx3_q[NW-1] ^ den3_q[NW-1];
      negy4_q   <= numy3_q[NW-1] ^ den3_q[NW-1];
      anx4_q    <= numx3_q[NW-1] ? NW'(-numx3_q) : NW'(numx3_q);
      any4_q    <= numy3_q[NW-1] ? NW'(-numy3_q) : NW'(numy3_q);
      aden4_q   <= den3_q[NW-1] ? NW'(-den3_q) : NW'(den3_q);

      zero5_q   <= zero4_q;
      inside5_q <= inside4_q;
      negx5_q   <= negx4_q;
      negy5_q   <= negy4_q;
      aden5_q   <= aden4_q;
      ppxl5_q   <= PP_W'(anx4_q[HALF-1:0]) * PP_W'(scl_x);
      ppxh5_q   <= PP_W'(anx4_q[NW-1:HALF]) * PP_W'(scl_x);
      ppyl5_q   <= PP_W'(any4_q[HALF-1:0]) * PP_W'(scl_y);
      ppyh5_q   <= PP_W'(any4_q[NW-1:HALF]) * PP_W'(scl_y);

      zero6_q   <= zero5_q;
      inside6_q <= inside5_q;
      negx6_q   <= negx5_q;
      negy6_q   <= negy5_q;
      aden6_q   <= aden5_q;
      mx6_q     <= (MW'(ppxh5_q) << HALF) + MW'(ppxl5_q);
      my6_q     <= (MW'(ppyh5_q) << HALF) + MW'(ppyl5_q);
    end
  end

  // dividers
  logic          dvx_valid, dvy_valid;
  logic [MW-1:0] qx, qy;
  logic [2:0]    sidex;
  logic          sidey;

  wtsp_div #(.NUM_W(MW), .DEN_W(NW), .SIDE_W(3)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (mx6_q),
    .den_i   (aden6_q),
    .side_i  ({negx6_q, zero6_q, inside6_q}),
    .valid_o (dvx_valid),
    .quo_o   (qx),
    .side_o  (sidex)
  );

  wtsp_div #(.NUM_W(MW), .DEN_W(NW), .SIDE_W(1)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (my6_q),
    .den_i   (aden6_q),
    .side_i  (negy6_q),
    .valid_o (dvy_valid),
    .quo_o   (qy),
    .side_o  (sidey)
  );

  function automatic logic signed [COORD_W-1:0] finish(input logic [MW-1:0] q,
                                                       input logic neg,
                                                       input logic [EXT_W-1:0] org);
    logic [62:0]        mag;
    logic signed [63:0] v;
    mag = (q > MW'(LIM)) ? LIM[62:0] : q[62:0];
    v   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    v   = v + $signed(64'(org) << F);
    if (v > 64'sd2147483647) begin
      finish = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      finish = 32'sh8000_0000;
    end else begin
      finish = v[31:0];
    end
  endfunction

  wtsp_res_t res;

  always_comb begin
    res.zero_depth  = sidex[1];
    res.inside_view = sidex[0];
    res.screen_x    = sidex[1] ? '0 : finish(qx, sidex[2], org_x);
    res.screen_y    = sidex[1] ? '0 : finish(qy, sidey, org_y);
  end

  // output buffer
  wtsp_res_t buf_q [2];
  logic      wr_ptr_q, rd_ptr_q;

  assign push  = en && dvx_valid;
  assign pop   = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= res;
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.screen_x    = buf_q[rd_ptr_q].screen_x;
  assign out_o.screen_y    = buf_q[rd_ptr_q].screen_y;
  assign out_o.inside_view = buf_q[rd_ptr_q].inside_view;
  assign out_o.zero_depth  = buf_q[rd_ptr_q].zero_depth;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q == 2'd2 |-> !push)
    else $error("push into full output buffer");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
      dvx_valid == dvy_valid)
    else $error("divider lanes out of step");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && out_o.zero_depth |->
        out_o.screen_x == '0 && out_o.screen_y == '0 && !out_o.inside_view)
    else $error("zero divisor word carries coordinates");

endmodule
